[rtl/core/rddh_pkg.sv]
// ----------------------------------------------------------------------------
// rddh_pkg
// Shared types and constants for the register dependency distance histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rddh_pkg;

   localparam logic [7:0] MAX_SPACING_RESET = 8'd100;
   localparam int unsigned CLEAR_ADDR_W = 9;

   typedef enum logic [1:0] {
      FUNC_NEW_INSN  = 2'd0,
      FUNC_REG_WRITE = 2'd1,
      FUNC_REG_READ  = 2'd2,
      FUNC_BIN_QUERY = 2'd3
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [8:0]  reg_number;
      logic [6:0]  bin_index;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] distance;
      logic        counted;
      logic [63:0] bin_count;
   } rsp_payload_type;

   // table clearing sweep after reset
   typedef struct packed {
      logic                    active;
      logic [CLEAR_ADDR_W-1:0] addr;
   } clear_type;

   // first stage to histogram stage
   typedef struct packed {
      logic        valid;
      logic [31:0] distance;
      logic        hit;
      logic [7:0]  bin;
      logic        bin_ok;
   } hist_req_type;

endpackage

`default_nettype wire

[rtl/core/register_dependency_distance_histogram_top.sv]
// ----------------------------------------------------------------------------
// register_dependency_distance_histogram_top
// Read-after-write distance profiler with a saturating 64-bit histogram.
// ----------------------------------------------------------------------------
//  channel  ports                                   direction
//  req      req_valid / req_ready / req_payload     in
//  rsp      rsp_valid / rsp_ready / rsp_payload     out
//  csr      csr_write_enable / csr_write_data       in (max_spacing)
//
//  One beat accepted per cycle while req_ready is high; it flows s1, s2, output reg.
//  The histogram read-modify-write is the critical loop, closed by forwarding.
//  After reset a sweep zeroes both tables: max(min(REG_SLOTS,512),
//  min(HIST_DEPTH,256)) entries (512 at defaults), with req_ready low.
//  rsp_ready low with rsp_valid high freezes the whole pipeline; the output reg holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module register_dependency_distance_histogram_top
   import rddh_pkg::*;
#(
   parameter int REG_SLOTS  = 512,
   parameter int HIST_DEPTH = 128
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_write_enable,
   input  wire logic [7:0]      csr_write_data
);

   // reg_number is 9 bits and distances counted stay below 256
   localparam int LW_DEPTH  = (REG_SLOTS < 512) ? REG_SLOTS : 512;
   localparam int HIST_EFF  = (HIST_DEPTH < 256) ? HIST_DEPTH : 256;
   localparam int CLEAR_LEN = (LW_DEPTH > HIST_EFF) ? LW_DEPTH : HIST_EFF;

   logic [7:0]      max_spacing_val_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   clear_type       clear;
   hist_req_type    hist_req;
   logic            rsp_next_valid;
   rsp_payload_type rsp_next;
   logic            adv;
   logic            accept;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !clear.active;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_spacing_val_ff <= MAX_SPACING_RESET;
      end else begin
         if (csr_write_enable) begin
            max_spacing_val_ff <= csr_write_data;
         end
      end
   end

   rddh_clear_seq #(
      .CLEAR_LEN (CLEAR_LEN)
   ) u_clear_seq (
      .clock (clock),
      .reset (reset),
      .clear (clear)
   );

   rddh_last_write #(
      .LW_DEPTH   (LW_DEPTH),
      .HIST_DEPTH (HIST_DEPTH)
   ) u_last_write (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .accept      (accept),
      .req_payload (req_payload),
      .max_spacing (max_spacing_val_ff),
      .clear       (clear),
      .hist_req    (hist_req)
   );

   rddh_histogram #(
      .HIST_EFF (HIST_EFF)
   ) u_histogram (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .clear          (clear),
      .hist_req       (hist_req),
      .rsp_next_valid (rsp_next_valid),
      .rsp_next       (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

[rtl/core/rddh_clear_seq.sv]
// ----------------------------------------------------------------------------
// rddh_clear_seq
// Post-reset sweep that zeroes both tables, one entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rddh_clear_seq
   import rddh_pkg::*;
#(
   parameter int CLEAR_LEN = 512
) (
   input  wire logic clock,
   input  wire logic reset,
   output clear_type clear
);

   localparam int CLR_W = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;

   logic             active_ff;
   logic [CLR_W-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         addr_ff   <= '0;
      end else if (active_ff) begin
         if (addr_ff == CLR_W'(CLEAR_LEN - 1)) begin
            active_ff <= 1'b0;
         end else begin
            addr_ff <= addr_ff + CLR_W'(1);
         end
      end
   end

   assign clear.active = active_ff;
   assign clear.addr   = CLEAR_ADDR_W'(addr_ff);

endmodule

`default_nettype wire

[rtl/core/rddh_last_write.sv]
// ----------------------------------------------------------------------------
// rddh_last_write
// Instruction counter, last-write table and the distance stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rddh_last_write
   import rddh_pkg::*;
#(
   parameter int LW_DEPTH   = 512,
   parameter int HIST_DEPTH = 128
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic            accept,
   input  wire req_payload_type req_payload,
   input  wire logic [7:0]      max_spacing,
   input  wire clear_type       clear,
   output hist_req_type         hist_req
);

   localparam int LW_AW = $clog2(LW_DEPTH);

   logic [31:0]      count_ff;
   logic [31:0]      lw_mem [LW_DEPTH];
   logic [31:0]      lw_rdata_ff;

   logic             s1_valid_ff;
   req_payload_type  s1_item_ff;
   logic [31:0]      s1_count_ff;
   logic             s1_reg_ok_ff;

   logic             reg_ok;
   logic [LW_AW-1:0] lw_idx;
   logic [31:0]      rd_distance;
   logic             is_read;

   assign reg_ok = {23'd0, req_payload.reg_number} < 32'(LW_DEPTH);
   assign lw_idx = req_payload.reg_number[LW_AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept && req_payload.func == FUNC_NEW_INSN) begin
         count_ff <= count_ff + 32'd1;
      end
   end

   // one write per cycle: sweep first, else a write beat; every accepted beat reads
   always_ff @(posedge clock) begin
      if (clear.active) begin
         if ({23'd0, clear.addr} < 32'(LW_DEPTH)) begin
            lw_mem[clear.addr[LW_AW-1:0]] <= '0;
         end
      end else if (accept && req_payload.func == FUNC_REG_WRITE && reg_ok) begin
         lw_mem[lw_idx] <= count_ff;
      end
      if (accept) begin
         lw_rdata_ff <= lw_mem[lw_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff   <= req_payload;
         s1_count_ff  <= count_ff;
         s1_reg_ok_ff <= reg_ok;
      end
   end

   assign rd_distance = s1_count_ff - lw_rdata_ff - 32'd1;
   assign is_read     = (s1_item_ff.func == FUNC_REG_READ) && s1_reg_ok_ff;

   always_comb begin
      hist_req.valid    = s1_valid_ff;
      hist_req.distance = is_read ? rd_distance : 32'd0;
      hist_req.hit      = is_read && (rd_distance < {24'd0, max_spacing})
                          && (rd_distance < 32'(HIST_DEPTH));
      hist_req.bin      = is_read ? rd_distance[7:0] : {1'b0, s1_item_ff.bin_index};
      hist_req.bin_ok   = (s1_item_ff.func == FUNC_BIN_QUERY)
                          && ({25'd0, s1_item_ff.bin_index} < 32'(HIST_DEPTH));
   end

endmodule

`default_nettype wire

[rtl/core/rddh_histogram.sv]
// ----------------------------------------------------------------------------
// rddh_histogram
// Histogram bin memory with saturating read-modify-write and forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rddh_histogram
   import rddh_pkg::*;
#(
   parameter int HIST_EFF = 128
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire clear_type    clear,
   input  wire hist_req_type hist_req,
   output logic              rsp_next_valid,
   output rsp_payload_type   rsp_next
);

   localparam int HIST_AW = (HIST_EFF > 1) ? $clog2(HIST_EFF) : 1;

   logic [63:0]        hist_mem [HIST_EFF];
   logic [63:0]        hist_rdata_ff;
   logic               s2_valid_ff;
   hist_req_type       s2_ff;
   logic               fwd_valid_ff;
   logic [HIST_AW-1:0] fwd_addr_ff;
   logic [63:0]        fwd_data_ff;

   logic [HIST_AW-1:0] s2_addr;
   logic [63:0]        cur;
   logic [63:0]        bump;
   logic               do_write;

   assign s2_addr  = s2_ff.bin[HIST_AW-1:0];
   // bin written on the edge this beat's read was issued: read saw old data
   assign cur      = (fwd_valid_ff && fwd_addr_ff == s2_addr) ? fwd_data_ff
                                                              : hist_rdata_ff;
   assign bump     = (&cur) ? cur : cur + 64'd1;
   assign do_write = adv && s2_valid_ff && s2_ff.hit;

   always_ff @(posedge clock) begin
      if (clear.active) begin
         if ({23'd0, clear.addr} < 32'(HIST_EFF)) begin
            hist_mem[clear.addr[HIST_AW-1:0]] <= '0;
         end
      end else if (do_write) begin
         hist_mem[s2_addr] <= bump;
      end
      if (adv) begin
         hist_rdata_ff <= hist_mem[hist_req.bin[HIST_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff  <= hist_req.valid;
         fwd_valid_ff <= s2_valid_ff && s2_ff.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff       <= hist_req;
         fwd_addr_ff <= s2_addr;
         fwd_data_ff <= bump;
      end
   end

   always_comb begin
      rsp_next_valid     = s2_valid_ff;
      rsp_next.distance  = s2_ff.distance;
      rsp_next.counted   = s2_ff.hit;
      rsp_next.bin_count = s2_ff.bin_ok ? cur : 64'd0;
   end

endmodule

`default_nettype wire

[tb/tb_register_dependency_distance_histogram_top.sv]
// ----------------------------------------------------------------------------
// tb_register_dependency_distance_histogram_top
// Self-checking bench for the read-after-write distance profiler. A short
// table of directed beats, then randomized instruction streams under several
// max_spacing settings and flow-control mixes. Every result is compared
// field by field against literal table values or an in-bench model of the
// counter, the last-write table and the saturating histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_register_dependency_distance_histogram_top
   import rddh_pkg::*;
;

   localparam int REG_SLOTS    = 512;
   localparam int HIST_BINS    = 128;
   localparam int PHASES       = 8;
   localparam int PHASE_BEATS  = 215;
   localparam int POOL_MAX     = 24;
   localparam int DRAIN_CYCLES = 6;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      req_payload_type beat;
      bit              literal;
      rsp_payload_type rsp;
   } directed_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [7:0]      csr_write_data = '0;

   // model state
   logic [31:0] insn_count;
   logic [31:0] last_write [REG_SLOTS];
   logic [63:0] spacing_bins [HIST_BINS];
   logic [7:0]  max_spacing;

   rsp_payload_type  predicted_q [$];
   directed_row_type directed_rows [$];
   logic [8:0]       reg_pool [POOL_MAX];
   int unsigned      pool_span;
   int unsigned      send_idle_pct = 0;
   int unsigned      stall_pct = 0;
   int unsigned      mismatches = 0;
   int unsigned      beats_sent = 0;
   int unsigned      reads_binned = 0;
   int unsigned      reads_missed = 0;
   int unsigned      queries_nonzero = 0;

   always #5 clock = ~clock;

   register_dependency_distance_histogram_top #(
      .REG_SLOTS  (REG_SLOTS),
      .HIST_DEPTH (HIST_BINS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   function automatic rsp_payload_type profile_event(input req_payload_type p);
      rsp_payload_type r;
      r = '0;
      case (p.func)
         FUNC_NEW_INSN: begin
            insn_count = insn_count + 32'd1;
         end
         FUNC_REG_WRITE: begin
            last_write[p.reg_number] = insn_count;
         end
         FUNC_REG_READ: begin
            r.distance = insn_count - last_write[p.reg_number] - 32'd1;
            if (r.distance < {24'd0, max_spacing} && r.distance < HIST_BINS) begin
               // bins stick at all-ones
               if (spacing_bins[r.distance[6:0]] != '1)
                  spacing_bins[r.distance[6:0]] = spacing_bins[r.distance[6:0]] + 64'd1;
               r.counted = 1'b1;
            end
         end
         default: begin
            r.bin_count = spacing_bins[p.bin_index];
         end
      endcase
      return r;
   endfunction

   function automatic req_payload_type random_beat();
      req_payload_type p;
      int unsigned     pick;
      pick = $urandom_range(99, 0);
      if ($urandom_range(99, 0) < 85)
         p.reg_number = reg_pool[$urandom_range(pool_span - 1, 0)];
      else
         p.reg_number = 9'($urandom_range(REG_SLOTS - 1, 0));
      if ($urandom_range(99, 0) < 60)
         p.bin_index = 7'($urandom_range(15, 0));
      else
         p.bin_index = 7'($urandom_range(HIST_BINS - 1, 0));
      if (pick < 40)
         p.func = FUNC_NEW_INSN;
      else if (pick < 62)
         p.func = FUNC_REG_WRITE;
      else if (pick < 90)
         p.func = FUNC_REG_READ;
      else
         p.func = FUNC_BIN_QUERY;
      return p;
   endfunction

   task automatic add_row(input func_type f, input logic [8:0] r, input logic [6:0] b,
                          input bit literal, input logic [31:0] d, input logic c,
                          input logic [63:0] n);
      directed_row_type row;
      row.beat.func       = f;
      row.beat.reg_number = r;
      row.beat.bin_index  = b;
      row.literal         = literal;
      row.rsp.distance    = d;
      row.rsp.counted     = c;
      row.rsp.bin_count   = n;
      directed_rows.push_back(row);
   endtask

   task automatic send_beat(input req_payload_type p, input bit literal,
                            input rsp_payload_type literal_rsp);
      int unsigned     gap;
      rsp_payload_type predicted;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      predicted = profile_event(p);
      predicted_q.push_back(literal ? literal_rsp : predicted);
      beats_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (predicted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_spacing(input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      max_spacing = value;
   endtask

   // result side: random backpressure and the scoreboard
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] unexpected result beat: distance=%h counted=%b count=%h",
                        $time, rsp_payload.distance, rsp_payload.counted,
                        rsp_payload.bin_count);
         end else begin
            want = predicted_q.pop_front();
            if (rsp_payload.distance !== want.distance ||
                rsp_payload.counted !== want.counted ||
                rsp_payload.bin_count !== want.bin_count) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"[%0t] mismatch: distance exp %h got %h, counted exp %b got %b,",
                            " count exp %h got %h"}, $time, want.distance,
                           rsp_payload.distance, want.counted, rsp_payload.counted,
                           want.bin_count, rsp_payload.bin_count);
            end
            if (want.counted)
               reads_binned++;
            else if (want.distance != 32'd0)
               reads_missed++;
            if (want.bin_count != 64'd0)
               queries_nonzero++;
         end
      end
      rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
   end

   initial begin
      #5_000_000;
      $display("register_dependency_distance_histogram_top verification failed");
      $finish;
   end

   initial begin
      logic [7:0] spacing_plan [PHASES];
      insn_count  = '0;
      max_spacing = MAX_SPACING_RESET;
      foreach (last_write[i]) last_write[i] = '0;
      foreach (spacing_bins[i]) spacing_bins[i] = '0;
      pool_span = 8;
      foreach (reg_pool[i]) reg_pool[i] = 9'($urandom_range(REG_SLOTS - 1, 0));

      // after reset: counter 0, max_spacing 100, all tables clear
      add_row(FUNC_BIN_QUERY, 9'd0,   7'd0,    1, 32'd0,         1'b0, 64'd0);
      add_row(FUNC_BIN_QUERY, 9'd0,   7'd127,  1, 32'd0,         1'b0, 64'd0);
      add_row(FUNC_REG_READ,  9'd0,   7'd0,    1, 32'hFFFF_FFFF, 1'b0, 64'd0);
      add_row(FUNC_REG_READ,  9'd511, 7'd127,  1, 32'hFFFF_FFFF, 1'b0, 64'd0);
      add_row(FUNC_REG_WRITE, 9'd511, 7'd0,    1, 32'd0,         1'b0, 64'd0);
      add_row(FUNC_NEW_INSN,  9'd0,   7'd0,    1, 32'd0,         1'b0, 64'd0);
      add_row(FUNC_REG_READ,  9'd511, 7'd0,    1, 32'd0,         1'b1, 64'd0);
      add_row(FUNC_BIN_QUERY, 9'd0,   7'd0,    1, 32'd0,         1'b0, 64'd1);
      add_row(FUNC_NEW_INSN,  9'd0,   7'd0,    1, 32'd0,         1'b0, 64'd0);
      add_row(FUNC_NEW_INSN,  9'd0,   7'd0,    1, 32'd0,         1'b0, 64'd0);
      add_row(FUNC_REG_READ,  9'd511, 7'd0,    1, 32'd2,         1'b1, 64'd0);
      add_row(FUNC_REG_WRITE, 9'd0,   7'd0,    1, 32'd0,         1'b0, 64'd0);
      // write and read inside the same instruction wraps to all ones
      add_row(FUNC_REG_READ,  9'd0,   7'd0,    1, 32'hFFFF_FFFF, 1'b0, 64'd0);
      add_row(FUNC_REG_READ,  9'h155, 7'd0,    1, 32'd2,         1'b1, 64'd0);
      add_row(FUNC_BIN_QUERY, 9'd0,   7'd2,    1, 32'd0,         1'b0, 64'd2);
      add_row(FUNC_REG_WRITE, 9'h0AA, 7'h55,   0, '0, 1'b0, '0);
      add_row(FUNC_NEW_INSN,  9'h1FF, 7'h7F,   0, '0, 1'b0, '0);
      add_row(FUNC_REG_READ,  9'h0AA, 7'h2A,   0, '0, 1'b0, '0);
      add_row(FUNC_BIN_QUERY, 9'h1FF, 7'h55,   0, '0, 1'b0, '0);
      add_row(FUNC_BIN_QUERY, 9'h155, 7'h2A,   0, '0, 1'b0, '0);
      add_row(FUNC_BIN_QUERY, 9'h0AA, 7'd0,    0, '0, 1'b0, '0);

      spacing_plan[0] = 8'd1;
      spacing_plan[1] = 8'd128;
      spacing_plan[2] = 8'd0;
      spacing_plan[3] = 8'd255;
      spacing_plan[4] = MAX_SPACING_RESET;
      spacing_plan[5] = 8'($urandom_range(128, 1));
      spacing_plan[6] = 8'($urandom_range(128, 1));
      spacing_plan[7] = 8'd37;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].literal, directed_rows[i].rsp);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         write_max_spacing(spacing_plan[phase]);
         pool_span = $urandom_range(POOL_MAX, 2);
         foreach (reg_pool[i]) reg_pool[i] = 9'($urandom_range(REG_SLOTS - 1, 0));
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 71; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 71; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
         endcase
         repeat (PHASE_BEATS) send_beat(random_beat(), 1'b0, '0);
      end
      drain_results();

      $display("Ran %0d beats across %0d max_spacing settings (0, 1, 100, 128, 255 included)",
               beats_sent, PHASES);
      $display({"under four flow-control mixes: %0d reads binned, %0d past the limit,",
                " %0d nonzero bins read."}, reads_binned, reads_missed, queries_nonzero);
      if (mismatches == 0) begin
         $display("register_dependency_distance_histogram_top verification clean");
      end else begin
         $display("register_dependency_distance_histogram_top verification failed");
      end
      $finish;
   end

endmodule
